// File: src/ipv4hc_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ipv4hc_pkg
// Types, constants and helpers shared by the IPv4 header checker.
// ----------------------------------------------------------------------------
package ipv4hc_pkg;

   localparam logic [3:0] VERSION_V4   = 4'd4;
   localparam logic [3:0] MIN_IHL      = 4'd5;

   // word positions within the header
   localparam logic [4:0] WORD_TOTAL_LEN = 5'd1;
   localparam logic [4:0] WORD_PROTOCOL  = 5'd4;
   localparam logic [4:0] WORD_CHECKSUM  = 5'd5;
   localparam logic [4:0] WORD_DEST_HI   = 5'd8;
   localparam logic [4:0] WORD_DEST_LO   = 5'd9;

   localparam logic [7:0] PROTO_ICMP = 8'd1;
   localparam logic [7:0] PROTO_UDP  = 8'd17;

   typedef enum logic [2:0] {
      REASON_OK          = 3'd0,
      REASON_BAD_VERSION = 3'd1,
      REASON_SHORT_HDR   = 3'd2,
      REASON_WRONG_DEST  = 3'd3,
      REASON_BAD_CSUM    = 3'd4
   } reason_type;

   typedef enum logic [1:0] {
      DISP_DROP  = 2'd0,
      DISP_ICMP  = 2'd1,
      DISP_UDP   = 2'd2,
      DISP_OTHER = 2'd3
   } dispatch_type;

   typedef struct packed {
      logic        active;
      logic [4:0]  word_count;
      logic [4:0]  header_words;
      logic [15:0] running_sum;
      logic [15:0] stored_checksum;
      logic [15:0] datagram_len;
      logic [7:0]  protocol_seen;
      logic        dest_matches;
   } state_type;

   typedef struct packed {
      logic         accept;
      reason_type   reason;
      logic [7:0]   protocol;
      logic [15:0]  payload_length;
      logic [5:0]   header_bytes;
      dispatch_type dispatch;
   } result_type;

   localparam state_type STATE_RESET = '{
      active:          1'b0,
      word_count:      5'd0,
      header_words:    5'd0,
      running_sum:     16'd0,
      stored_checksum: 16'd0,
      datagram_len:    16'd0,
      protocol_seen:   8'd0,
      dest_matches:    1'b1
   };

   // ones'-complement add with end-around carry
   function automatic logic [15:0] ones_add(input logic [15:0] a, input logic [15:0] b);
      logic [16:0] s;
      s = {1'b0, a} + {1'b0, b};
      return s[15:0] + {15'd0, s[16]};
   endfunction

endpackage
`default_nettype wire

// File: src/ipv4hc_step.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ipv4hc_step
// Per-word header update: next parser state and the result a word causes.
// ----------------------------------------------------------------------------
module ipv4hc_step (
   input  wire logic [15:0]           word,
   input  wire logic                  first,
   input  wire logic [31:0]           my_ip,
   input  wire ipv4hc_pkg::state_type state_cur,
   output ipv4hc_pkg::state_type      state_nxt,
   output logic                       emit,
   output ipv4hc_pkg::result_type     result
);

   logic [3:0]  version;
   logic [3:0]  ihl;
   logic [4:0]  count_nxt;
   logic [5:0]  hbytes;

   assign version   = word[15:12];
   assign ihl       = word[11:8];
   assign count_nxt = state_cur.word_count + 5'd1;
   assign hbytes    = {state_cur.header_words, 1'b0};

   always_comb begin
      state_nxt = state_cur;
      emit      = 1'b0;
      result    = '{accept: 1'b0, reason: ipv4hc_pkg::REASON_OK, protocol: 8'd0,
                    payload_length: 16'd0, header_bytes: 6'd0,
                    dispatch: ipv4hc_pkg::DISP_DROP};

      if (first) begin
         state_nxt.active = 1'b0;
         if (version != ipv4hc_pkg::VERSION_V4) begin
            emit          = 1'b1;
            result.reason = ipv4hc_pkg::REASON_BAD_VERSION;
         end else if (ihl < ipv4hc_pkg::MIN_IHL) begin
            emit          = 1'b1;
            result.reason = ipv4hc_pkg::REASON_SHORT_HDR;
         end else begin
            state_nxt.active          = 1'b1;
            state_nxt.header_words    = {ihl, 1'b0};
            state_nxt.word_count      = 5'd1;
            state_nxt.running_sum     = word;
            state_nxt.stored_checksum = 16'd0;
            state_nxt.datagram_len    = 16'd0;
            state_nxt.protocol_seen   = 8'd0;
            state_nxt.dest_matches    = 1'b1;
         end
      end else if (state_cur.active) begin
         unique case (state_cur.word_count)
            ipv4hc_pkg::WORD_TOTAL_LEN: state_nxt.datagram_len    = word;
            ipv4hc_pkg::WORD_PROTOCOL:  state_nxt.protocol_seen   = word[7:0];
            ipv4hc_pkg::WORD_CHECKSUM:  state_nxt.stored_checksum = word;
            ipv4hc_pkg::WORD_DEST_HI: begin
               if (word != my_ip[31:16]) state_nxt.dest_matches = 1'b0;
            end
            ipv4hc_pkg::WORD_DEST_LO: begin
               if (word != my_ip[15:0]) state_nxt.dest_matches = 1'b0;
            end
            default: ;
         endcase
         if (state_cur.word_count != ipv4hc_pkg::WORD_CHECKSUM) begin
            state_nxt.running_sum = ipv4hc_pkg::ones_add(state_cur.running_sum, word);
         end
         state_nxt.word_count = count_nxt;

         // last header word: close out the header
         if (count_nxt == state_cur.header_words) begin
            state_nxt.active = 1'b0;
            emit             = 1'b1;
            if (!state_nxt.dest_matches) begin
               result.reason = ipv4hc_pkg::REASON_WRONG_DEST;
            end else if (~state_nxt.running_sum != state_nxt.stored_checksum) begin
               result.reason = ipv4hc_pkg::REASON_BAD_CSUM;
            end else begin
               result.accept         = 1'b1;
               result.protocol       = state_nxt.protocol_seen;
               result.payload_length = state_nxt.datagram_len - {10'd0, hbytes};
               result.header_bytes   = hbytes;
               if (state_nxt.protocol_seen == ipv4hc_pkg::PROTO_ICMP) begin
                  result.dispatch = ipv4hc_pkg::DISP_ICMP;
               end else if (state_nxt.protocol_seen == ipv4hc_pkg::PROTO_UDP) begin
                  result.dispatch = ipv4hc_pkg::DISP_UDP;
               end else begin
                  result.dispatch = ipv4hc_pkg::DISP_OTHER;
               end
            end
         end
      end
   end

endmodule
`default_nettype wire

// File: src/ipv4_header_checker_core.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ipv4_header_checker_core
// Checks a streamed IPv4 header and reports accept or reject with dispatch.
// ----------------------------------------------------------------------------
// Usage:
//   req_*  : one 16-bit header word per transfer, req_first_word marks word 0.
//   rsp_*  : one result transfer per finished header, or at once on word 0
//            when the version or header length is bad.
//   csr_*  : write channel for the own address (my_ip), always ready. Write
//            it only while no header is in flight.
// Path: a word that ends a header reaches its result through the input
//   register, then the result register.
// Throughput: one word per cycle unless a result is blocked (see Stall); the
//   single ones'-complement adder in the update path sets that figure.
// Reset: synchronous; clears the valid bits of both pipeline registers, the
//   parser state and my_ip. The block waits for a first word afterwards.
// Stall: while rsp_stall holds a pending result, words that make no result
//   keep flowing; a word that makes a result waits in the input register
//   until the result register frees up. req_stall rises only then.
// ----------------------------------------------------------------------------
module ipv4_header_checker_core (
   input  wire logic        clock,
   input  wire logic        reset,
   // header word channel
   input  wire logic        req_valid,
   output logic             req_stall,
   input  wire logic [15:0] req_header_word,
   input  wire logic        req_first_word,
   // result channel
   output logic             rsp_valid,
   input  wire logic        rsp_stall,
   output logic             rsp_accept,
   output logic [2:0]       rsp_reject_reason,
   output logic [7:0]       rsp_protocol,
   output logic [15:0]      rsp_payload_length,
   output logic [5:0]       rsp_header_bytes,
   output logic [1:0]       rsp_dispatch,
   // configuration
   input  wire logic        csr_valid,
   output logic             csr_ready,
   input  wire logic [31:0] csr_data
);

   // input register
   logic        in_valid_ff, in_valid_in;
   logic [15:0] in_word_ff;
   logic        in_first_ff;

   // parser state and own address
   ipv4hc_pkg::state_type  state_ff, state_in, state_nxt;
   logic [31:0]            my_ip_ff;

   // result register
   logic                   rsp_valid_ff, rsp_valid_in;
   ipv4hc_pkg::result_type rsp_ff, step_result;

   logic step_emit;
   logic advance;
   logic req_xfer;

   ipv4hc_step u_step (
      .word      (in_word_ff),
      .first     (in_first_ff),
      .my_ip     (my_ip_ff),
      .state_cur (state_ff),
      .state_nxt (state_nxt),
      .emit      (step_emit),
      .result    (step_result)
   );

   // Advance the held word unless it makes a result that has nowhere to go.
   assign advance   = in_valid_ff && (!step_emit || !rsp_valid_ff || !rsp_stall);
   assign req_stall = in_valid_ff && !advance;
   assign req_xfer  = req_valid && !req_stall;

   assign in_valid_in  = req_xfer ? 1'b1 : (advance ? 1'b0 : in_valid_ff);
   assign state_in     = advance ? state_nxt : state_ff;
   assign rsp_valid_in = (advance && step_emit) ? 1'b1 :
                         (rsp_stall ? rsp_valid_ff : 1'b0);

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         state_ff     <= ipv4hc_pkg::STATE_RESET;
         rsp_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Capture the word on transfer; hold it while stalled.
   always_ff @(posedge clock) begin
      if (req_xfer) begin
         in_word_ff  <= req_header_word;
         in_first_ff <= req_first_word;
      end
   end

   // Load the result payload only when a result leaves the update logic.
   always_ff @(posedge clock) begin
      if (advance && step_emit) begin
         rsp_ff <= step_result;
      end
   end

   // Own address register; always ready for a write transfer.
   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         my_ip_ff <= 32'd0;
      end else if (csr_valid && csr_ready) begin
         my_ip_ff <= csr_data;
      end
   end

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_accept         = rsp_ff.accept;
   assign rsp_reject_reason  = rsp_ff.reason;
   assign rsp_protocol       = rsp_ff.protocol;
   assign rsp_payload_length = rsp_ff.payload_length;
   assign rsp_header_bytes   = rsp_ff.header_bytes;
   assign rsp_dispatch       = rsp_ff.dispatch;

   // An accepted header never carries a reject reason or a drop class.
   a_accept_clean: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_ff.accept) |->
      (rsp_ff.reason == ipv4hc_pkg::REASON_OK && rsp_ff.dispatch != ipv4hc_pkg::DISP_DROP))
      else $error("accepted result with reject reason or drop class");

   // A rejected header reports drop and zeroed length fields.
   a_reject_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && !rsp_ff.accept) |->
      (rsp_ff.dispatch == ipv4hc_pkg::DISP_DROP && rsp_ff.payload_length == 16'd0 &&
       rsp_ff.header_bytes == 6'd0 && rsp_ff.reason != ipv4hc_pkg::REASON_OK))
      else $error("rejected result with nonzero fields");

   // While a header is open, the word count stays below the header length.
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      state_ff.active |-> (state_ff.word_count < state_ff.header_words &&
                           state_ff.header_words >= 5'd10))
      else $error("word count ran past header length");

   // A held result that is stalled blocks only a word that makes a result.
   a_stall_cause: assert property (@(posedge clock) disable iff (reset)
      req_stall |-> (in_valid_ff && step_emit && rsp_valid_ff && rsp_stall))
      else $error("input stalled without a blocked result");

endmodule
`default_nettype wire

// File: bench/tb_ipv4_header_checker_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_ipv4_header_checker_core
// Streams IPv4 headers into the checker and scores every verdict it returns.
// Headers are built with valid or broken fields and checksums, sent word by
// word with random gaps, and each verdict is checked against a local model
// of the parser that runs on every accepted word. The own address is changed
// between phases while nothing is in flight.
// ----------------------------------------------------------------------------
module tb_ipv4_header_checker_core;

   typedef struct packed {
      logic [15:0] word;
      logic        first;
   } hdr_word_type;

   // ------------------------------------------------------------------------
   // Clock, reset and block ports
   // ------------------------------------------------------------------------
   logic        clock = 1'b0;
   logic        reset = 1'b1;

   logic        req_valid = 1'b0;
   logic        req_stall;
   logic [15:0] req_header_word = 16'd0;
   logic        req_first_word = 1'b0;

   logic        rsp_valid;
   logic        rsp_stall = 1'b0;
   logic        rsp_accept;
   logic [2:0]  rsp_reject_reason;
   logic [7:0]  rsp_protocol;
   logic [15:0] rsp_payload_length;
   logic [5:0]  rsp_header_bytes;
   logic [1:0]  rsp_dispatch;

   logic        csr_valid = 1'b0;
   logic        csr_ready;
   logic [31:0] csr_data = 32'd0;

   always #6 clock = ~clock;

   ipv4_header_checker_core dut (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_stall          (req_stall),
      .req_header_word    (req_header_word),
      .req_first_word     (req_first_word),
      .rsp_valid          (rsp_valid),
      .rsp_stall          (rsp_stall),
      .rsp_accept         (rsp_accept),
      .rsp_reject_reason  (rsp_reject_reason),
      .rsp_protocol       (rsp_protocol),
      .rsp_payload_length (rsp_payload_length),
      .rsp_header_bytes   (rsp_header_bytes),
      .rsp_dispatch       (rsp_dispatch),
      .csr_valid          (csr_valid),
      .csr_ready          (csr_ready),
      .csr_data           (csr_data)
   );

   // ------------------------------------------------------------------------
   // Shared bench state
   // ------------------------------------------------------------------------
   hdr_word_type           word_q[$];     // words waiting for the driver
   ipv4hc_pkg::result_type verdict_q[$];  // verdicts owed by the block, oldest first
   int          words_queued = 0;
   int          words_taken = 0;
   int          error_count = 0;
   bit          steady_run = 1'b0;  // no gaps and no stalls while set

   // model copy of the parser state and of the own address
   ipv4hc_pkg::state_type hdr_st = ipv4hc_pkg::STATE_RESET;
   logic [31:0] own_addr = 32'd0;

   // header under construction
   logic [15:0] hdr_buf [0:29];
   int          hdr_len;

   // ------------------------------------------------------------------------
   // Helpers
   // ------------------------------------------------------------------------
   function automatic logic [15:0] csum_fold(input logic [15:0] a, input logic [15:0] b);
      logic [16:0] s;
      s = {1'b0, a} + {1'b0, b};
      return s[15:0] + {15'd0, s[16]};
   endfunction

   // mostly back to back, some short gaps, a few long ones
   function automatic int pick_gap();
      int r;
      r = $urandom_range(0, 99);
      if (r < 60) return 0;
      if (r < 90) return $urandom_range(1, 3);
      return $urandom_range(8, 40);
   endfunction

   task automatic report_mismatch(input string msg);
      if (error_count < 50) $display("%0t ns  mismatch: %s", $time, msg);
      error_count++;
   endtask

   task automatic check_field(input string name, input logic [15:0] got,
                              input logic [15:0] want);
      if (got !== want)
         report_mismatch($sformatf("%s got %0h, expected %0h", name, got, want));
   endtask

   // Advance the parser model by one accepted word; push a verdict when the
   // word ends a header or rejects one at word 0.
   task automatic predict_word(input logic [15:0] w, input logic first);
      ipv4hc_pkg::result_type v;
      logic [5:0]  hbytes;
      v = '0;
      if (first) begin
         hdr_st.active = 1'b0;
         if (w[15:12] != ipv4hc_pkg::VERSION_V4) begin
            v.reason = ipv4hc_pkg::REASON_BAD_VERSION;
            verdict_q.push_back(v);
         end else if (w[11:8] < ipv4hc_pkg::MIN_IHL) begin
            v.reason = ipv4hc_pkg::REASON_SHORT_HDR;
            verdict_q.push_back(v);
         end else begin
            hdr_st = ipv4hc_pkg::STATE_RESET;
            hdr_st.active = 1'b1;
            hdr_st.header_words = {w[11:8], 1'b0};
            hdr_st.word_count = 5'd1;
            hdr_st.running_sum = w;
         end
      end else if (hdr_st.active) begin
         case (hdr_st.word_count)
            ipv4hc_pkg::WORD_TOTAL_LEN: hdr_st.datagram_len = w;
            ipv4hc_pkg::WORD_PROTOCOL:  hdr_st.protocol_seen = w[7:0];
            ipv4hc_pkg::WORD_CHECKSUM:  hdr_st.stored_checksum = w;
            // compare with the address in force when the word arrives
            ipv4hc_pkg::WORD_DEST_HI:
               if (w != own_addr[31:16]) hdr_st.dest_matches = 1'b0;
            ipv4hc_pkg::WORD_DEST_LO:
               if (w != own_addr[15:0]) hdr_st.dest_matches = 1'b0;
            default: ;
         endcase
         if (hdr_st.word_count != ipv4hc_pkg::WORD_CHECKSUM)
            hdr_st.running_sum = csum_fold(hdr_st.running_sum, w);
         hdr_st.word_count = hdr_st.word_count + 5'd1;
         if (hdr_st.word_count == hdr_st.header_words) begin
            hdr_st.active = 1'b0;
            hbytes = {hdr_st.header_words, 1'b0};
            if (!hdr_st.dest_matches) begin
               v.reason = ipv4hc_pkg::REASON_WRONG_DEST;
            end else if (~hdr_st.running_sum != hdr_st.stored_checksum) begin
               v.reason = ipv4hc_pkg::REASON_BAD_CSUM;
            end else begin
               v.accept = 1'b1;
               v.reason = ipv4hc_pkg::REASON_OK;
               v.protocol = hdr_st.protocol_seen;
               v.payload_length = hdr_st.datagram_len - {10'd0, hbytes};
               v.header_bytes = hbytes;
               if (hdr_st.protocol_seen == ipv4hc_pkg::PROTO_ICMP)
                  v.dispatch = ipv4hc_pkg::DISP_ICMP;
               else if (hdr_st.protocol_seen == ipv4hc_pkg::PROTO_UDP)
                  v.dispatch = ipv4hc_pkg::DISP_UDP;
               else
                  v.dispatch = ipv4hc_pkg::DISP_OTHER;
            end
            verdict_q.push_back(v);
         end
      end
   endtask

   // ------------------------------------------------------------------------
   // Stimulus building
   // ------------------------------------------------------------------------
   task automatic push_word(input logic [15:0] w, input logic first);
      hdr_word_type item;
      item.word = w;
      item.first = first;
      word_q.push_back(item);
      words_queued++;
   endtask

   task automatic queue_words(input int from, input int upto);
      for (int i = from; i < upto; i++) push_word(hdr_buf[i], i == 0);
   endtask

   // Fill hdr_buf with one header. Random filler goes into the other words;
   // the checksum is made right unless bad_csum asks for a corrupt one.
   task automatic build_header(input logic [3:0] version, input logic [3:0] ihl,
                               input logic [15:0] total_len, input logic [7:0] proto,
                               input logic [31:0] dest, input bit bad_csum);
      logic [15:0] sum;
      for (int i = 0; i < 30; i++) hdr_buf[i] = 16'($urandom);
      hdr_len = (ihl >= 4'd5) ? 2 * ihl : 1 + ihl;
      hdr_buf[0] = {version, ihl, hdr_buf[0][7:0]};
      hdr_buf[1] = total_len;
      hdr_buf[4] = {hdr_buf[4][15:8], proto};
      hdr_buf[8] = dest[31:16];
      hdr_buf[9] = dest[15:0];
      sum = 16'd0;
      for (int i = 0; i < hdr_len; i++)
         if (i != 5) sum = csum_fold(sum, hdr_buf[i]);
      hdr_buf[5] = ~sum;
      if (bad_csum) hdr_buf[5] = hdr_buf[5] ^ 16'($urandom_range(1, 65535));
   endtask

   task automatic send_header(input logic [3:0] version, input logic [3:0] ihl,
                              input logic [15:0] total_len, input logic [7:0] proto,
                              input logic [31:0] dest, input bit bad_csum);
      build_header(version, ihl, total_len, proto, dest, bad_csum);
      queue_words(0, hdr_len);
   endtask

   // Wait until every word is taken and every verdict is in, then give a word
   // that makes no verdict time to leave the pipeline.
   task automatic wait_quiet();
      do @(posedge clock); while (words_taken != words_queued || verdict_q.size() != 0);
      repeat (4) @(posedge clock);
   endtask

   task automatic write_own_addr(input logic [31:0] addr);
      @(posedge clock);
      csr_valid <= 1'b1;
      csr_data <= addr;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
      own_addr = addr;
   endtask

   // ------------------------------------------------------------------------
   // Driver: present queued words, hold them while stalled, predict on each
   // transfer
   // ------------------------------------------------------------------------
   int           idle_left = 0;
   hdr_word_type next_item;

   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else begin
         if (req_valid && !req_stall) begin
            predict_word(req_header_word, req_first_word);
            words_taken++;
         end
         // load a new word only when the bus is free or was just taken
         if (!req_valid || !req_stall) begin
            if (idle_left != 0) begin
               idle_left--;
               req_valid <= 1'b0;
            end else if (word_q.size() != 0) begin
               next_item = word_q.pop_front();
               req_valid <= 1'b1;
               req_header_word <= next_item.word;
               req_first_word <= next_item.first;
               idle_left = steady_run ? 0 : pick_gap();
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // ------------------------------------------------------------------------
   // Monitor: score each verdict transfer, stall at random
   // ------------------------------------------------------------------------
   int                     stall_left = 0;
   ipv4hc_pkg::result_type want_v;

   always @(posedge clock) begin
      if (reset) begin
         rsp_stall <= 1'b0;
      end else begin
         if (rsp_valid && !rsp_stall) begin
            if (verdict_q.size() == 0) begin
               report_mismatch("verdict arrived with none outstanding");
            end else begin
               want_v = verdict_q.pop_front();
               check_field("accept", 16'(rsp_accept), 16'(want_v.accept));
               check_field("reject_reason", 16'(rsp_reject_reason), 16'(want_v.reason));
               check_field("protocol", 16'(rsp_protocol), 16'(want_v.protocol));
               check_field("payload_length", rsp_payload_length, want_v.payload_length);
               check_field("header_bytes", 16'(rsp_header_bytes),
                           16'(want_v.header_bytes));
               check_field("dispatch", 16'(rsp_dispatch), 16'(want_v.dispatch));
            end
         end
         if (stall_left != 0) stall_left--;
         else if (!steady_run && $urandom_range(0, 99) < 25) stall_left = pick_gap() + 1;
         rsp_stall <= (stall_left != 0);
      end
   end

   // ------------------------------------------------------------------------
   // Test sequence
   // ------------------------------------------------------------------------
   initial begin
      logic [31:0] dest;
      logic [31:0] addr;
      logic [15:0] total_len;
      logic [7:0]  proto;
      logic [3:0]  ihl;
      int          pick;
      int          cut;
      int          counted;
      int          waited;

      repeat (2) @(posedge clock);
      reset <= 1'b0;

      // --- directed part ---
      write_own_addr(32'hC0A8_0101);
      send_header(4'd4, 4'd5, 16'd28, ipv4hc_pkg::PROTO_UDP, own_addr, 0);
      send_header(4'd4, 4'd5, 16'd84, ipv4hc_pkg::PROTO_ICMP, own_addr, 0);
      send_header(4'd4, 4'd5, 16'hFFFF, 8'd6, own_addr, 0);
      send_header(4'd4, 4'd5, 16'd4, 8'd0, own_addr, 0);       // length wraps
      send_header(4'd4, 4'd15, 16'd60, 8'hFF, own_addr, 0);    // longest header
      // bad version; rest ignored
      send_header(4'd6, 4'd5, 16'd40, ipv4hc_pkg::PROTO_UDP, own_addr, 0);
      send_header(4'd0, 4'd0, 16'd0, 8'd0, own_addr, 0);
      send_header(4'hF, 4'hF, 16'hFFFF, 8'hFF, own_addr, 0);
      // short header, then wrong destination
      send_header(4'd4, 4'd4, 16'd20, ipv4hc_pkg::PROTO_UDP, own_addr, 0);
      send_header(4'd4, 4'd0, 16'd20, ipv4hc_pkg::PROTO_UDP, own_addr, 0);
      send_header(4'd4, 4'd5, 16'd30, ipv4hc_pkg::PROTO_UDP,
                  own_addr ^ 32'h8000_0000, 0);
      send_header(4'd4, 4'd5, 16'd30, ipv4hc_pkg::PROTO_UDP,
                  own_addr ^ 32'h0000_0001, 0);
      // bad checksum
      send_header(4'd4, 4'd5, 16'd30, ipv4hc_pkg::PROTO_UDP, own_addr, 1);
      // destination and checksum both wrong: destination wins
      send_header(4'd4, 4'd5, 16'd30, ipv4hc_pkg::PROTO_ICMP, ~own_addr, 1);
      // stray words while idle
      push_word(16'hFFFF, 1'b0);
      push_word(16'h0000, 1'b0);
      // abandon a header part way, then start a good one
      build_header(4'd4, 4'd5, 16'd50, ipv4hc_pkg::PROTO_UDP, own_addr, 0);
      queue_words(0, 6);
      send_header(4'd4, 4'd6, 16'd50, ipv4hc_pkg::PROTO_UDP, own_addr, 0);

      // change the address between the halves of one header
      addr = 32'h0A00_00FE;
      build_header(4'd4, 4'd5, 16'd100, ipv4hc_pkg::PROTO_UDP, addr, 0);
      queue_words(0, 8);
      wait_quiet();
      write_own_addr(addr);
      queue_words(8, hdr_len);

      // extreme addresses
      wait_quiet();
      write_own_addr(32'h0000_0000);
      send_header(4'd4, 4'd5, 16'd20, ipv4hc_pkg::PROTO_ICMP, 32'h0000_0000, 0);
      send_header(4'd4, 4'd5, 16'd20, ipv4hc_pkg::PROTO_ICMP, 32'h0000_0001, 0);
      wait_quiet();
      write_own_addr(32'hFFFF_FFFF);
      send_header(4'd4, 4'd5, 16'd20, ipv4hc_pkg::PROTO_UDP, 32'hFFFF_FFFF, 0);
      send_header(4'd4, 4'd5, 16'd20, ipv4hc_pkg::PROTO_UDP, 32'hFFFE_FFFF, 0);

      // --- random part: phases with a fresh address each ---
      for (int phase = 0; phase < 6; phase++) begin
         wait_quiet();
         if (phase == 3) write_own_addr(32'hFFFF_FFFF);
         else if (phase == 4) write_own_addr(32'h0000_0000);
         else write_own_addr($urandom);
         steady_run = (phase == 2);
         counted = 0;
         while (counted < 95) begin
            pick = $urandom_range(0, 99);
            ihl = ($urandom_range(0, 9) < 7) ? 4'd5 : 4'($urandom_range(6, 15));
            if (pick < 6) begin
               // any version but four
               send_header(4'($urandom_range(5, 19)), 4'($urandom), 16'($urandom),
                           8'($urandom), $urandom, 0);
               counted++;
            end else if (pick < 11) begin
               send_header(4'd4, 4'($urandom_range(0, 4)), 16'($urandom),
                           8'($urandom), own_addr, 0);
               counted++;
            end else if (pick < 15) begin
               repeat ($urandom_range(1, 3)) push_word(16'($urandom), 1'b0);
            end else begin
               dest = own_addr;
               case ($urandom_range(0, 19))
                  0: dest[31:16] = dest[31:16] ^ 16'($urandom_range(1, 65535));
                  1: dest[15:0] = dest[15:0] ^ 16'($urandom_range(1, 65535));
                  default: ;
               endcase
               case ($urandom_range(0, 9))
                  0, 1, 2: proto = ipv4hc_pkg::PROTO_UDP;
                  3, 4, 5: proto = ipv4hc_pkg::PROTO_ICMP;
                  default: proto = 8'($urandom);
               endcase
               if ($urandom_range(0, 4) == 0) total_len = 16'($urandom);
               else total_len = 16'(4 * ihl + $urandom_range(0, 1480));
               build_header(4'd4, ihl, total_len, proto, dest, $urandom_range(0, 9) == 0);
               // now and then cut the header short; the next one abandons it
               cut = ($urandom_range(0, 7) == 0) ? $urandom_range(1, hdr_len - 1) : hdr_len;
               queue_words(0, cut);
               counted += cut;
            end
         end
      end
      steady_run = 1'b0;

      // --- drain and finish ---
      do @(posedge clock); while (words_taken != words_queued);
      waited = 0;
      while (verdict_q.size() != 0 && waited < 4000) begin
         @(posedge clock);
         waited++;
      end
      repeat (8) @(posedge clock);
      if (verdict_q.size() != 0)
         report_mismatch($sformatf("%0d verdicts never arrived", verdict_q.size()));
      if (error_count == 0) begin
         $display("tb_ipv4_header_checker_core: clean");
      end else begin
         $display("tb_ipv4_header_checker_core: errors");
      end
      $finish;
   end

   // hard stop in case the block hangs
   initial begin
      #5_000_000;
      $display("tb_ipv4_header_checker_core: errors");
      $finish;
   end

endmodule
